// File: rtl/pid_controller_timestamped_macros.svh
// Assertion macros for the timestamped PID controller.
// Used by files under rtl; no dependencies.
`ifndef PID_CONTROLLER_TIMESTAMPED_MACROS_SVH
`define PID_CONTROLLER_TIMESTAMPED_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PID_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PID_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PID_ASSERT(lbl, clk, rst_n, prop, msg)
`define PID_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/pidts_pkg.sv
// Package for the timestamped PID controller: widths, register indexes,
// controller/datapath command and status types. No dependencies.
`default_nettype none
package pidts_pkg;
  localparam int unsigned DefFracBits = 16;
  localparam int unsigned DataW = 32;
  localparam int unsigned EpsW = 31;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegPropGain = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegIntegMin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIntegMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDeadband = 3'd5;

  localparam logic OpCompute = 1'b0;
  localparam logic OpClear = 1'b1;

  typedef enum logic [3:0] {
    CmdNone, CmdLoad, CmdMulP, CmdMulDead, CmdMulInt, CmdInteg,
    CmdMulI, CmdMulD, CmdDivStart, CmdFinish
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctl_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic dt_zero;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/pidts_if.sv
// Valid/ready channel interfaces for the timestamped PID controller.
// Depends on pidts_pkg.
`default_nettype none
interface pidts_in_if;
  logic valid;
  logic ready;
  logic op;
  logic signed [31:0] target;
  logic signed [31:0] measured;
  logic [31:0] time_stamp;
  modport source (output valid, op, target, measured, time_stamp, input ready);
  modport sink (input valid, op, target, measured, time_stamp, output ready);
endinterface

interface pidts_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] drive;
  logic computed;
  logic zero_interval;
  modport source (output valid, drive, computed, zero_interval, input ready);
  modport sink (input valid, drive, computed, zero_interval, output ready);
endinterface
`default_nettype wire

// File: rtl/pid_controller_timestamped.sv
// Top level of the timestamped PID controller with integral clamp.
// Depends on pidts_pkg, pidts_if, pidts_ctrl, pidts_datapath.
`default_nettype none
// Timestamped PID controller, signed fixed point with FracBits fraction bits.
// A compute transaction carries setpoint, measurement and a tick stamp; the
// first one after reset only records the sample. Later ones return
// kp*e + ki*I + kd*(e-e_prev)/dt, saturated to 32 bits, with I clamped to
// [integ_min, integ_max] and zeroed inside the deadband. A clear transaction
// zeroes I only and returns drive 0. One transaction at a time: a compute
// with nonzero dt makes five passes of the shared radix-4 multiplier, then
// a bit-serial divide and a finish step; with dt zero the divide is
// skipped; clear and first-sample transactions go straight from idle to
// the output state. The output register holds a result until taken and no
// new transaction is accepted meanwhile; the user must make config writes
// only when idle, which the block itself does not enforce.
module pid_controller_timestamped #(
  parameter int unsigned FracBits = pidts_pkg::DefFracBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pidts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  pidts_in_if.sink                           in_if,
  pidts_out_if.source                        out_if
);
  import pidts_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic computed;
  logic have_prev_q;

  // tracks the recorded first sample for the controller
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) have_prev_q <= 1'b0;
    else if (ctl.cmd == CmdLoad && in_if.op == OpCompute) have_prev_q <= 1'b1;
  end

  pidts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_op_i(in_if.op),
    .have_prev_i(have_prev_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .ctl_o(ctl)
  );

  pidts_datapath #(.FracBits(FracBits)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .op_i(in_if.op), .target_i(in_if.target), .measured_i(in_if.measured),
    .stamp_i(in_if.time_stamp), .ctl_i(ctl), .sts_o(sts),
    .drive_o(out_if.drive), .computed_o(computed), .zero_o(out_if.zero_interval)
  );
  assign out_if.computed = computed;
endmodule
`default_nettype wire

// File: rtl/pidts_mul.sv
// Sequential signed 33x33 multiplier, two bits per cycle (radix-4 shift-add).
// Depends on pidts_pkg only for style consistency.
`default_nettype none
module pidts_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic                    done_o,
  output logic signed [65:0]      p_o
);
  import pidts_pkg::*;
  logic [32:0] mag_a_q, mag_a_d;
  logic [32:0] mag_b_q, mag_b_d;
  logic [65:0] acc_q, acc_d;
  logic        neg_q, neg_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [65:0] step;

  always_comb begin
    step = 66'(mag_a_q) * 66'(mag_b_q[1:0]);
    mag_a_d = mag_a_q;
    mag_b_d = mag_b_q;
    acc_d = acc_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      mag_a_d = a_i[32] ? 33'(-a_i) : 33'(a_i);
      mag_b_d = b_i[32] ? 33'(-b_i) : 33'(b_i);
      neg_d = a_i[32] ^ b_i[32];
      acc_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + (step << {cnt_q, 1'b0});
      mag_b_d = mag_b_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd16) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    acc_q <= acc_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign p_o = neg_q ? -$signed(acc_q) : $signed(acc_q);
endmodule
`default_nettype wire

// File: rtl/pidts_div.sv
// Sequential restoring divider: 66-bit signed dividend by 32-bit unsigned
// divisor, quotient truncated toward zero, one bit per cycle.
`default_nettype none
module pidts_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [65:0] num_i,
  input  wire logic [31:0]        den_i,
  output logic                    done_o,
  output logic signed [65:0]      quo_o
);
  import pidts_pkg::*;
  logic [65:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q[31:0], quo_q[65]};
    if (start_i) begin
      quo_d = num_i[65] ? 66'(-num_i) : 66'(num_i);
      rem_d = '0;
      den_d = den_i;
      neg_d = num_i[65];
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[64:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[64:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd65) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule
`default_nettype wire

// File: rtl/pidts_datapath.sv
// Datapath: config registers, controller state, shared multiplier and
// divider, term accumulation. Depends on pidts_pkg, pidts_mul, pidts_div.
`default_nettype none
`include "pid_controller_timestamped_macros.svh"
module pidts_datapath #(
  parameter int unsigned FracBits = pidts_pkg::DefFracBits
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pidts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic                          op_i,
  input  wire logic signed [31:0]            target_i,
  input  wire logic signed [31:0]            measured_i,
  input  wire logic [31:0]                   stamp_i,
  input  wire pidts_pkg::ctl_t               ctl_i,
  output pidts_pkg::sts_t                    sts_o,
  output logic signed [31:0]                 drive_o,
  output logic                               computed_o,
  output logic                               zero_o
);
  import pidts_pkg::*;
  localparam logic signed [65:0] DLim = 66'sd1 <<< 60;

  logic signed [31:0] kp_q, ki_q, kd_q, imin_q, imax_q;
  logic [30:0]        eps_q;
  logic               have_prev_q;
  logic signed [31:0] prev_err_q, integ_q;
  logic [31:0]        prev_stamp_q;
  logic signed [31:0] err_q;
  logic [31:0]        dt_q;
  logic               op_q;
  logic signed [65:0] sum_q;
  logic               dead_q;
  logic signed [31:0] drive_q;
  logic               computed_q, zero_q;

  logic               mul_start, div_start;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p, div_q;
  logic               mul_done, div_done;
  logic signed [32:0] diff_raw;
  logic signed [31:0] err_sat;
  logic signed [65:0] ishift, iacc, dlim, total;
  logic [63:0]        mag;

  assign diff_raw = 33'(target_i) - 33'(measured_i);
  always_comb begin
    if (diff_raw > 33'sh0_7FFF_FFFF) err_sat = 32'sh7FFF_FFFF;
    else if (diff_raw < -33'sh0_8000_0000) err_sat = 32'sh8000_0000;
    else err_sat = diff_raw[31:0];
  end

  pidts_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );
  pidts_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(mul_p), .den_i(dt_q),
    .done_o(div_done), .quo_o(div_q)
  );

  always_comb begin
    mul_start = 1'b0;
    mul_a = 33'(kp_q);
    mul_b = 33'(err_q);
    div_start = 1'b0;
    case (ctl_i.cmd)
      CmdMulP: mul_start = 1'b1;
      CmdMulDead: begin
        mul_start = 1'b1;
        mul_a = $signed({2'b00, eps_q});
        mul_b = $signed({1'b0, dt_q});
      end
      CmdMulInt: begin
        mul_start = 1'b1;
        mul_a = 33'(err_q);
        mul_b = $signed({1'b0, dt_q});
      end
      CmdMulI: begin
        mul_start = 1'b1;
        mul_a = 33'(ki_q);
        mul_b = 33'(integ_q);
      end
      CmdMulD: begin
        mul_start = 1'b1;
        mul_a = 33'(kd_q);
        mul_b = 33'(err_q) - 33'(prev_err_q);
      end
      CmdDivStart: div_start = 1'b1;
      default: ;
    endcase
  end

  assign mag = 64'(err_q[31] ? 33'(-33'(err_q)) : 33'(err_q)) << FracBits;
  assign ishift = mul_p >>> FracBits;
  assign iacc = 66'(integ_q) + ishift;
  assign dlim = (div_q > DLim) ? DLim : ((div_q < -DLim) ? -DLim : div_q);
  // derivative term is zero when the interval is zero
  assign total = sum_q + ((dt_q == '0) ? 66'sd0 : dlim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0; ki_q <= '0; kd_q <= '0;
      imin_q <= 32'sh8000_0000; imax_q <= 32'sh7FFF_FFFF; eps_q <= '0;
      have_prev_q <= 1'b0; prev_err_q <= '0; prev_stamp_q <= '0; integ_q <= '0;
      computed_q <= 1'b0; zero_q <= 1'b0; drive_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPropGain: kp_q <= cfg_data_i;
          RegIntegGain: ki_q <= cfg_data_i;
          RegDerivGain: kd_q <= cfg_data_i;
          RegIntegMin: imin_q <= cfg_data_i;
          RegIntegMax: imax_q <= cfg_data_i;
          RegDeadband: eps_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      case (ctl_i.cmd)
        CmdLoad: begin
          drive_q <= '0; computed_q <= 1'b0; zero_q <= 1'b0;
          if (op_i == OpClear) integ_q <= '0;
          else if (!have_prev_q) begin
            have_prev_q <= 1'b1;
            prev_err_q <= err_sat;
            prev_stamp_q <= stamp_i;
          end
        end
        CmdInteg: begin
          if (!dead_q) integ_q <= '0;
          else if (iacc < 66'(imin_q)) integ_q <= (imin_q > imax_q) ? imax_q : imin_q;
          else if (iacc > 66'(imax_q)) integ_q <= imax_q;
          else integ_q <= iacc[31:0];
        end
        CmdFinish: begin
          prev_err_q <= err_q;
          prev_stamp_q <= prev_stamp_q + dt_q;
          computed_q <= 1'b1;
          zero_q <= (dt_q == '0);
          if (total > 66'sh0_7FFF_FFFF) drive_q <= 32'sh7FFF_FFFF;
          else if (total < -66'sh0_8000_0000) drive_q <= 32'sh8000_0000;
          else drive_q <= total[31:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdLoad: begin
        err_q <= err_sat;
        dt_q <= stamp_i - prev_stamp_q;
        op_q <= op_i;
      end
      CmdMulDead: sum_q <= mul_p >>> FracBits;
      CmdMulInt: dead_q <= $unsigned(mul_p[63:0]) < mag;
      CmdMulD: sum_q <= sum_q + (mul_p >>> FracBits);
      CmdDivStart: if (dt_q == '0) sum_q <= sum_q;
      default: ;
    endcase
  end

  assign sts_o.mul_done = mul_done;
  assign sts_o.div_done = div_done;
  assign sts_o.dt_zero = (dt_q == '0) || op_q == OpClear;
  assign drive_o = drive_q;
  assign computed_o = computed_q;
  assign zero_o = zero_q;

  `PID_ASSERT(a_integ_range, clk_i, rst_ni,
    (ctl_i.cmd == CmdInteg && dead_q && imin_q <= imax_q) |=>
      (integ_q >= imin_q && integ_q <= imax_q), "integral outside clamp")
  `PID_ASSERT(a_zero_flag, clk_i, rst_ni,
    (zero_q && computed_q) |-> (dt_q == '0), "zero flag without zero interval")
  `PID_ASSERT(a_mul_div_excl, clk_i, rst_ni,
    !(mul_start && div_start), "multiplier and divider started together")
endmodule
`default_nettype wire

// File: rtl/pidts_ctrl.sv
// Controller FSM sequencing the datapath per transaction.
// Depends on pidts_pkg.
`default_nettype none
`include "pid_controller_timestamped_macros.svh"
module pidts_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            in_op_i,
  input  wire logic            have_prev_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire pidts_pkg::sts_t sts_i,
  output pidts_pkg::ctl_t      ctl_o
);
  import pidts_pkg::*;
  typedef enum logic [3:0] {
    StIdle, StP, StPw, StDead, StDeadw, StInt, StIntw, StI, StIw, StD, StDw,
    StDiv, StDivw, StFin, StOut
  } state_e;
  state_e state_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && !out_valid_q) begin
          if (in_op_i == OpClear || !have_prev_i) begin
            state_q <= StOut;
          end else begin
            state_q <= StP;
          end
        end
        StP: state_q <= StPw;
        StPw: if (sts_i.mul_done) state_q <= StDead;
        StDead: state_q <= StDeadw;
        StDeadw: if (sts_i.mul_done) state_q <= StInt;
        StInt: state_q <= StIntw;
        StIntw: if (sts_i.mul_done) state_q <= StI;
        StI: state_q <= StIw;
        StIw: if (sts_i.mul_done) state_q <= StD;
        StD: state_q <= StDw;
        StDw: if (sts_i.mul_done) state_q <= sts_i.dt_zero ? StFin : StDiv;
        StDiv: state_q <= StDivw;
        StDivw: if (sts_i.div_done) state_q <= StFin;
        StFin: state_q <= StOut;
        StOut: begin
          out_valid_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    ctl_o.cmd = CmdNone;
    case (state_q)
      StIdle: if (in_valid_i && !out_valid_q) ctl_o.cmd = CmdLoad;
      StP: ctl_o.cmd = CmdMulP;
      StDead: ctl_o.cmd = CmdMulDead;
      StInt: ctl_o.cmd = CmdMulInt;
      StIntw: if (sts_i.mul_done) ctl_o.cmd = CmdInteg;
      StI: ctl_o.cmd = CmdMulI;
      StD: ctl_o.cmd = CmdMulD;
      StDiv: ctl_o.cmd = CmdDivStart;
      StFin: ctl_o.cmd = CmdFinish;
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;

  `PID_ASSERT(a_no_accept_busy, clk_i, rst_ni,
    (state_q != StIdle) |-> !in_ready_o, "accept while busy")
  `PID_ASSERT_RST(a_reset_idle, clk_i,
    !rst_ni |=> (state_q == StIdle), "not idle after reset")
endmodule
`default_nettype wire

// File: tb/sv/tb_pid_controller_timestamped.sv
// Testbench for the timestamped PID controller: random and directed samples
// checked against a behavioral fixed-point predictor of the block.
// Depends on pidts_pkg, pidts_if and the RTL top pid_controller_timestamped.
`timescale 1ns / 1ps
module tb_pid_controller_timestamped;
  import pidts_pkg::*;

  localparam int unsigned FB = DefFracBits;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic op;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic [31:0] stamp;
  } sample_t;

  typedef struct {
    logic signed [31:0] drive;
    logic computed;
    logic zero_interval;
  } drive_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  pidts_in_if in_ch ();
  pidts_out_if out_ch ();

  pid_controller_timestamped uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state and shadow registers
  logic signed [31:0] kp, ki, kd, imin, imax;
  logic [30:0] eps;
  bit have_prev;
  logic signed [31:0] prev_err, integ;
  logic [31:0] prev_stamp;

  sample_t pending_samples[$];
  drive_t expected_drives[$];
  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  int idle_cycles = 0;
  bit in_taken = 0;

  function automatic longint floor_div(longint x);
    return x >>> FB; // arithmetic shift is floor division
  endfunction

  function automatic drive_t predict_drive(sample_t s);
    drive_t r;
    longint e, p, it, d, sum, acc;
    logic [31:0] dt;
    logic [63:0] mag, thr;
    r.drive = 0; r.computed = 0; r.zero_interval = 0;
    if (s.op == OpClear) begin
      integ = 0;
      return r;
    end
    e = longint'(s.target) - longint'(s.measured);
    if (e > 64'sd2147483647) e = 64'sd2147483647;
    if (e < -64'sd2147483648) e = -64'sd2147483648;
    if (!have_prev) begin
      have_prev = 1;
      prev_err = e[31:0];
      prev_stamp = s.stamp;
      return r;
    end
    dt = s.stamp - prev_stamp;
    p = floor_div(longint'(kp) * e);
    mag = (e < 0 ? -e : e) << FB;
    thr = {33'd0, eps} * {32'd0, dt};
    if (mag > thr) begin
      acc = longint'(integ) + floor_div(e * longint'({32'd0, dt}));
      if (acc < longint'(imin)) acc = imin;
      if (acc > longint'(imax)) acc = imax;
      integ = acc[31:0];
    end else begin
      integ = 0;
    end
    it = floor_div(longint'(ki) * longint'(integ));
    if (dt == 0) begin
      d = 0;
      r.zero_interval = 1;
    end else begin
      d = (longint'(kd) * (e - longint'(prev_err))) / longint'({32'd0, dt});
      if (d > (64'sd1 <<< 60)) d = 64'sd1 <<< 60;
      if (d < -(64'sd1 <<< 60)) d = -(64'sd1 <<< 60);
    end
    sum = p + it + d;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    prev_err = e[31:0];
    prev_stamp = s.stamp;
    r.drive = sum[31:0];
    r.computed = 1;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Input handshake seen at the last rising edge
  always @(posedge clk_i) begin
    in_taken <= in_ch.valid && in_ch.ready;
  end

  // Driver: one transaction per accepted handshake, new data at falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_t s;
          s = pending_samples.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op <= s.op;
          in_ch.target <= s.target;
          in_ch.measured <= s.measured;
          in_ch.time_stamp <= s.stamp;
          expected_drives.push_back(predict_drive(s));
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_drives.size() == 0) begin
        report_mismatch("unexpected result", out_ch.drive, 0);
      end else begin
        drive_t x;
        x = expected_drives.pop_front();
        if (out_ch.drive !== x.drive) report_mismatch("drive", out_ch.drive, x.drive);
        if (out_ch.computed !== x.computed)
          report_mismatch("computed", out_ch.computed, x.computed);
        if (out_ch.zero_interval !== x.zero_interval)
          report_mismatch("zero_interval", out_ch.zero_interval, x.zero_interval);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegPropGain:  kp = val;
      RegIntegGain: ki = val;
      RegDerivGain: kd = val;
      RegIntegMin:  imin = val;
      RegIntegMax:  imax = val;
      RegDeadband:  eps = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_samples.size() == 0 && expected_drives.size() == 0);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom();
      default: return $signed($urandom_range(2 << FB)) - (1 << FB);
    endcase
  endfunction

  task automatic push(logic op, logic [31:0] t, logic [31:0] m, logic [31:0] st);
    sample_t s;
    s.op = op; s.target = t; s.measured = m; s.stamp = st;
    pending_samples.push_back(s);
  endtask

  // Random phase: mostly a steady time base with small errors
  task automatic random_phase(int n, ref logic [31:0] clock_ticks);
    logic [31:0] t, m;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: clock_ticks = $urandom();
        1: ;
        2: clock_ticks += $urandom_range(3);
        default: clock_ticks += $urandom_range(2000, 1);
      endcase
      if ($urandom_range(4) == 0) begin
        t = $urandom(); m = $urandom();
      end else begin
        t = $signed($urandom_range(1 << 20)) - (1 << 19);
        m = $signed($urandom_range(1 << 20)) - (1 << 19);
      end
      push($urandom_range(15) == 0 ? OpClear : OpCompute, t, m, clock_ticks);
    end
  endtask

  initial begin
    logic [31:0] ticks;
    kp = 0; ki = 0; kd = 0; imin = 32'h8000_0000; imax = 32'h7fff_ffff; eps = 0;
    have_prev = 0; prev_err = 0; prev_stamp = 0; integ = 0;
    in_ch.valid = 0; in_ch.op = OpCompute; in_ch.target = 0; in_ch.measured = 0;
    in_ch.time_stamp = 0; out_ch.ready = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed: clear before any sample, first sample, zero and wrapped dt
    write_reg(RegPropGain, 32'h0001_0000);
    write_reg(RegIntegGain, 32'h0000_8000);
    write_reg(RegDerivGain, 32'h0002_0000);
    write_reg(RegIntegMin, 32'hfff0_0000);
    write_reg(RegIntegMax, 32'h0010_0000);
    write_reg(RegDeadband, 32'h0000_0100);
    push(OpClear, 0, 0, 0);
    push(OpCompute, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_fff0);
    push(OpCompute, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0010);
    push(OpCompute, 32'h0001_0000, 0, 32'h0000_0010);
    push(OpCompute, 0, 32'h0001_0000, 32'h0000_0020);
    push(OpCompute, 5, 5, 32'h0001_0020);
    push(OpClear, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    push(OpCompute, 32'h0100_0000, 0, 32'h8001_0020);
    push(OpCompute, 32'hffff_ffff, 0, 32'h8001_0021);
    push(OpCompute, 32'h0000_0001, 0, 32'h8001_0021);
    drain();
    // Extreme gains, inverted clamp
    write_reg(RegPropGain, 32'h7fff_ffff);
    write_reg(RegIntegGain, 32'h8000_0000);
    write_reg(RegDerivGain, 32'h7fff_ffff);
    write_reg(RegIntegMin, 32'h0000_1000);
    write_reg(RegIntegMax, 32'hffff_0000);
    write_reg(RegDeadband, 32'h7fff_ffff);
    push(OpCompute, 32'h0fff_0000, 0, 32'h8001_0030);
    push(OpCompute, 32'h8000_0000, 0, 32'h8001_0031);
    push(OpCompute, 32'h0000_0100, 32'h0000_0200, 32'h8001_0031);
    push(OpCompute, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
    drain();

    // Receiver holds off long while the sender keeps offering
    ticks = 32'hffff_0000;
    hold_off = 1;
    random_phase(20, ticks);
    repeat (600) @(posedge clk_i);
    hold_off = 0;
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegPropGain, rand_gain());
      write_reg(RegIntegGain, rand_gain());
      write_reg(RegDerivGain, rand_gain());
      write_reg(RegIntegMin, ph == 5 ? 32'h8000_0000 : -$urandom_range(1 << 24));
      write_reg(RegIntegMax, ph == 5 ? 32'h7fff_ffff : $urandom_range(1 << 24));
      write_reg(RegDeadband, ph == 4 ? 32'h7fff_ffff : (ph[0] ? 0 : $urandom_range(1 << 17)));
      send_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 60 : 0;
      recv_idle_pct = (ph < 2) ? 60 : (ph < 4) ? 20 : 0;
      random_phase(185, ticks);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
